// ===== hw/rtl/acr_pkg.sv =====
// Package for the audio channel remap block: shared widths, register indexes,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package acr_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int MAP_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAP    = 2'd2;

    localparam logic [SLOT_W-1:0]  UNUSED_SLOT   = 4'hF;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 5'd2;
    localparam logic [MAP_W-1:0]   IN_MAP_RESET  = '0;
    localparam logic [MAP_W-1:0]   OUT_MAP_RESET = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_in;     // store the accepted sample
        logic [SLOT_W-1:0] wr_idx;    // input frame slot to store it in
        logic              map_en;    // apply one logical channel
        logic [SLOT_W-1:0] map_chan;  // logical channel being applied
        logic              load_out;  // load the output register
        logic [SLOT_W-1:0] out_idx;   // work frame slot to load
        logic              out_last;  // loaded slot closes the frame
    } acr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [COUNT_W-1:0] eff_count; // channel count clamped to 1..MAX
        logic               out_last;  // output register holds the last slot
    } acr_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/acr_ctrl.sv =====
// Controller of the audio channel remap block: fill, map and emit sequencing.
// Depends on acr_pkg.
`default_nettype none

module acr_ctrl
    import acr_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int IDX_W        = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire acr_status_t status,
    output acr_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_FILL = 3'b001,
        ST_MAP  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CHANNELS);
    localparam logic [IDX_W-1:0]   LAST_CHAN = IDX_W'(MAX_CHANNELS - 1);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]   chan_reg, chan_next;
    logic [COUNT_W-1:0] emit_reg, emit_next;
    logic               valid_reg, valid_next;
    logic [COUNT_W-1:0] fill_inc;
    logic [COUNT_W-1:0] emit_inc;
    logic               xfer;

    assign fill_inc = fill_reg + COUNT_W'(1);
    assign emit_inc = emit_reg + COUNT_W'(1);
    assign xfer     = valid_reg && m_tready;
    assign s_tready = (state_reg == ST_FILL);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        chan_next  = chan_reg;
        emit_next  = emit_reg;
        valid_next = valid_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_FILL: begin
                if (s_tvalid) begin
                    cmd.wr_in  = (fill_reg < MAX_COUNT);
                    cmd.wr_idx = fill_reg[SLOT_W-1:0];
                    if (fill_inc >= status.eff_count) begin
                        fill_next  = '0;
                        chan_next  = '0;
                        state_next = ST_MAP;
                    end else begin
                        fill_next = fill_inc;
                    end
                end
            end
            ST_MAP: begin
                cmd.map_en   = 1'b1;
                cmd.map_chan = SLOT_W'(chan_reg);
                if (chan_reg == LAST_CHAN) begin
                    emit_next  = '0;
                    valid_next = 1'b0;
                    state_next = ST_EMIT;
                end else begin
                    chan_next = chan_reg + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (xfer && status.out_last) begin
                    valid_next = 1'b0;
                    state_next = ST_FILL;
                end else if (!valid_reg || xfer) begin
                    cmd.load_out = 1'b1;
                    cmd.out_idx  = emit_reg[SLOT_W-1:0];
                    cmd.out_last = (emit_inc == status.eff_count);
                    emit_next    = emit_inc;
                    valid_next   = 1'b1;
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            chan_reg  <= '0;
            emit_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            chan_reg  <= chan_next;
            emit_reg  <= emit_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/acr_dpath.sv =====
// Datapath of the audio channel remap block: configuration registers, input
// and work frames, and the output register. Depends on acr_pkg.
`default_nettype none

module acr_dpath
    import acr_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int IDX_W        = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MAP_W-1:0]     cfg_wr_data,
    input  wire logic [SAMPLE_W-1:0]  in_sample,
    input  wire acr_cmd_t             cmd,
    output acr_status_t               status,
    output logic [SAMPLE_W-1:0]       out_sample,
    output logic [SLOT_W-1:0]         out_slot
);

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_CHANNELS);

    logic [COUNT_W-1:0]  count_reg;
    logic [MAP_W-1:0]    in_map_reg;
    logic [MAP_W-1:0]    out_map_reg;
    logic [SAMPLE_W-1:0] in_frame_reg   [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] work_frame_reg [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_last_reg;
    logic [COUNT_W-1:0]  eff_count;
    logic [SLOT_W-1:0]   dst_slot;
    logic [SLOT_W-1:0]   src_slot;
    logic                map_hit;

    always_comb begin
        if (count_reg == '0) begin
            eff_count = COUNT_W'(1);
        end else if (count_reg > MAX_COUNT) begin
            eff_count = MAX_COUNT;
        end else begin
            eff_count = count_reg;
        end
    end

    assign dst_slot = out_map_reg[{cmd.map_chan, 2'b00} +: SLOT_W];
    assign src_slot = in_map_reg[{cmd.map_chan, 2'b00} +: SLOT_W];
    // Unused channels and slots outside the current frame leave the work frame alone.
    assign map_hit  = cmd.map_en && (dst_slot != UNUSED_SLOT)
                      && ({1'b0, dst_slot} < eff_count)
                      && ({1'b0, src_slot} < eff_count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= COUNT_RESET;
            in_map_reg  <= IN_MAP_RESET;
            out_map_reg <= OUT_MAP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT: count_reg   <= cfg_wr_data[COUNT_W-1:0];
                CFG_INPUT_MAP:     in_map_reg  <= cfg_wr_data;
                CFG_OUTPUT_MAP:    out_map_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_in) begin
            in_frame_reg[cmd.wr_idx[IDX_W-1:0]] <= in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                work_frame_reg[i] <= '0;
            end
        end else if (map_hit) begin
            work_frame_reg[dst_slot[IDX_W-1:0]] <= in_frame_reg[src_slot[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_sample_reg <= work_frame_reg[cmd.out_idx[IDX_W-1:0]];
            out_slot_reg   <= cmd.out_idx;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign status.eff_count = eff_count;
    assign status.out_last  = out_last_reg;
    assign out_sample       = out_sample_reg;
    assign out_slot         = out_slot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/audio_channel_remap.sv =====
// Audio channel remap: an input frame fills at one sample per cycle while s_tvalid is
// high; on completion the MAX_CHANNELS logical channels are applied one per cycle, then
// the output register is loaded and the frame's slots leave at one transfer per cycle
// while m_tready is high.
// Reset is synchronous, active low: config returns to its defaults, the work frame clears
// to zero, and the input frame holds no defined contents until written.
`default_nettype none

module audio_channel_remap
    import acr_pkg::*;
#(
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port: index 0 channel_count, 1 input_map, 2 output_map.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MAP_W-1:0]     cfg_wr_data,
    // Input samples.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [15:0]          s_tdata,   // [15:0] in_sample
    // Remapped samples.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // [15:0] out_sample, [19:16] out_slot, zero
    output logic                      m_tlast    // frame_end
);

    // Width of a frame slot index for the configured depth.
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    acr_cmd_t            cmd;
    acr_status_t         status;
    logic [SAMPLE_W-1:0] out_sample;
    logic [SLOT_W-1:0]   out_slot;

    // The controller sequences filling, per-channel mapping and the output burst.
    acr_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the registers, both frames and the output register.
    acr_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_sample   (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .out_sample  (out_sample),
        .out_slot    (out_slot)
    );

    assign m_tdata = {4'b0000, out_slot, out_sample};
    assign m_tlast = status.out_last;

`ifndef SYNTHESIS
    // Input is never taken while a result is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // The transfer that closes a frame ends the burst.
    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output still valid after frame end");

    // Every emitted slot lies inside the current frame.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, out_slot} < status.eff_count))
        else $error("output slot beyond channel count");

    // A slot that is not the last is followed by the next slot.
    a_slot_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && out_slot == $past(out_slot) + 4'd1))
        else $error("output slots out of order");
`endif

endmodule

`default_nettype wire
